[rtl/tlbpt_pkg.sv]
// Shared types, widths and defaults for the TLB and page table translator.
package tlbpt_pkg;

    localparam int ADDR_W        = 16;
    localparam int FRAME_W       = 8;
    localparam int NEXT_FREE_W   = 9;
    localparam int COUNT_W       = 32;

    localparam int TLB_ENTRIES_DEF = 16;
    localparam int PAGE_BITS_DEF   = 8;
    localparam int OFFSET_BITS_DEF = 8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

[rtl/tlbpt_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/tlb_page_table_translator.sv]
// Top level of the TLB and page table address translator.
//
// A request carries one 16-bit logical address; its page number is looked up in a
// small TLB kept in recency order and, on a miss, in a page table held in a RAM.
// A page absent from both gets the next free frame (frames wrap after 256 faults
// without any check). The accept cycle issues the page table RAM read, and the
// following cycle, in which busy is high, compares all filled TLB slots in
// parallel against the page, picks the frame and writes the TLB and, on a
// fault, the page table back. The result appears on the result ports for
// exactly one cycle with done high, in the same cycle in which busy drops, so
// a new request may be accepted in the same cycle a result is shown. The
// receiver cannot stall: it must take every result in the cycle that done is
// high. After reset the block holds busy high while it clears the page table,
// one entry per cycle.
module tlb_page_table_translator
#(
    parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_BITS   = tlbpt_pkg::PAGE_BITS_DEF,
    parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [tlbpt_pkg::ADDR_W-1:0]    virt_addr,
    output logic                            done,
    output logic [tlbpt_pkg::FRAME_W-1:0]   frame_number,
    output logic [tlbpt_pkg::ADDR_W-1:0]    physical_address,
    output logic                            tlb_hit,
    output logic                            page_fault,
    output logic [tlbpt_pkg::COUNT_W-1:0]   hit_total,
    output logic [tlbpt_pkg::COUNT_W-1:0]   fault_total
);

    import tlbpt_pkg::*;

    localparam int PAGE_COUNT = 2 ** PAGE_BITS;
    localparam int FILL_W     = $clog2(TLB_ENTRIES + 1);
    localparam int IDX_W      = $clog2(TLB_ENTRIES);
    localparam int PT_W       = FRAME_W + 1;

    // Control state.
    state_t                  state_reg, state_next;
    logic [PAGE_BITS-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [FILL_W-1:0]       tlb_fill_reg, tlb_fill_next;
    logic [NEXT_FREE_W-1:0]  next_free_reg, next_free_next;
    logic [COUNT_W-1:0]      hit_cnt_reg, hit_cnt_next;
    logic [COUNT_W-1:0]      fault_cnt_reg, fault_cnt_next;
    logic                    done_reg, done_next;

    // Payload state.
    logic [ADDR_W-1:0]       addr_reg, addr_next;
    logic [PAGE_BITS-1:0]    tlb_page_reg [TLB_ENTRIES];
    logic [PAGE_BITS-1:0]    tlb_page_next [TLB_ENTRIES];
    logic [FRAME_W-1:0]      tlb_frame_reg [TLB_ENTRIES];
    logic [FRAME_W-1:0]      tlb_frame_next [TLB_ENTRIES];
    logic [FRAME_W-1:0]      frame_reg, frame_next;
    logic [ADDR_W-1:0]       phys_reg, phys_next;
    logic                    hit_reg, hit_next;
    logic                    fault_reg, fault_next;

    // Page table RAM: one entry per page, holding {present, frame}.
    logic                    pt_wr_en;
    logic [PAGE_BITS-1:0]    pt_wr_addr;
    logic [PT_W-1:0]         pt_wr_data;
    logic [PAGE_BITS-1:0]    pt_rd_addr;
    logic [PT_W-1:0]         pt_rd_data;

    // Datapath helpers.
    logic                    accept;
    logic [PAGE_BITS-1:0]    page;
    logic [OFFSET_BITS-1:0]  offset;
    logic                    found;
    logic [IDX_W-1:0]        found_idx;
    logic                    tlb_full;
    logic                    remove;
    logic [FILL_W-1:0]       rpos;
    logic [FILL_W-1:0]       new_fill;
    logic [FILL_W-1:0]       last;
    logic [FRAME_W-1:0]      frame;
    logic                    fault;

    tlbpt_ram #(
        .WIDTH (PT_W),
        .DEPTH (PAGE_COUNT)
    ) u_page_table (
        .clk     (clk),
        .wr_en   (pt_wr_en),
        .wr_addr (pt_wr_addr),
        .wr_data (pt_wr_data),
        .rd_addr (pt_rd_addr),
        .rd_data (pt_rd_data)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // The RAM read is issued in the accept cycle straight from the request, so
    // its data is ready in the lookup cycle. Missing high page bits read as zero.
    assign pt_rd_addr = PAGE_BITS'(32'(virt_addr) >> OFFSET_BITS);

    assign page   = PAGE_BITS'(32'(addr_reg) >> OFFSET_BITS);
    assign offset = addr_reg[OFFSET_BITS-1:0];

    // Parallel compare over the filled TLB slots. Pages in the TLB are unique,
    // so at most one slot matches.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = 0; i < TLB_ENTRIES; i++)
        begin
            if (!found && (FILL_W'(i) < tlb_fill_reg) && (tlb_page_reg[i] == page))
            begin
                found     = 1'b1;
                found_idx = IDX_W'(i);
            end
        end
    end

    assign tlb_full = (tlb_fill_reg == FILL_W'(TLB_ENTRIES));
    assign fault    = !found && !pt_rd_data[FRAME_W];

    always_comb
    begin
        if (found)
        begin
            frame = tlb_frame_reg[found_idx];
        end
        else if (pt_rd_data[FRAME_W])
        begin
            frame = pt_rd_data[FRAME_W-1:0];
        end
        else
        begin
            frame = next_free_reg[FRAME_W-1:0];
        end
    end

    // A hit removes its own slot; a miss on a full TLB removes the oldest one.
    // Either way the newer slots close the gap and the translation lands in the
    // newest slot.
    assign remove   = found || tlb_full;
    assign rpos     = found ? FILL_W'(found_idx) : '0;
    assign new_fill = remove ? tlb_fill_reg : tlb_fill_reg + FILL_W'(1);
    assign last     = new_fill - FILL_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        tlb_fill_next  = tlb_fill_reg;
        next_free_next = next_free_reg;
        hit_cnt_next   = hit_cnt_reg;
        fault_cnt_next = fault_cnt_reg;
        done_next      = 1'b0;
        addr_next      = addr_reg;
        frame_next     = frame_reg;
        phys_next      = phys_reg;
        hit_next       = hit_reg;
        fault_next     = fault_reg;
        tlb_page_next  = tlb_page_reg;
        tlb_frame_next = tlb_frame_reg;
        pt_wr_en       = 1'b0;
        pt_wr_addr     = page;
        pt_wr_data     = {1'b1, frame};

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the page table so that every page reads as absent.
                pt_wr_en     = 1'b1;
                pt_wr_addr   = clr_cnt_reg;
                pt_wr_data   = '0;
                clr_cnt_next = clr_cnt_reg + PAGE_BITS'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    addr_next  = virt_addr;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                for (int i = 0; i < TLB_ENTRIES - 1; i++)
                begin
                    if (remove && (FILL_W'(i) >= rpos) && (FILL_W'(i) < last))
                    begin
                        tlb_page_next[i]  = tlb_page_reg[i + 1];
                        tlb_frame_next[i] = tlb_frame_reg[i + 1];
                    end
                end
                tlb_page_next[last[IDX_W-1:0]]  = page;
                tlb_frame_next[last[IDX_W-1:0]] = frame;
                tlb_fill_next = new_fill;

                if (found && (hit_cnt_reg != '1))
                begin
                    hit_cnt_next = hit_cnt_reg + COUNT_W'(1);
                end
                if (fault)
                begin
                    pt_wr_en       = 1'b1;
                    next_free_next = next_free_reg + NEXT_FREE_W'(1);
                    if (fault_cnt_reg != '1)
                    begin
                        fault_cnt_next = fault_cnt_reg + COUNT_W'(1);
                    end
                end

                frame_next = frame;
                phys_next  = ADDR_W'((32'(frame) << OFFSET_BITS) | 32'(offset));
                hit_next   = found;
                fault_next = fault;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign hit_total   = hit_cnt_reg;
    assign fault_total = fault_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            tlb_fill_reg  <= '0;
            next_free_reg <= '0;
            hit_cnt_reg   <= '0;
            fault_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            tlb_fill_reg  <= tlb_fill_next;
            next_free_reg <= next_free_next;
            hit_cnt_reg   <= hit_cnt_next;
            fault_cnt_reg <= fault_cnt_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        tlb_page_reg  <= tlb_page_next;
        tlb_frame_reg <= tlb_frame_next;
        frame_reg     <= frame_next;
        phys_reg      <= phys_next;
        hit_reg       <= hit_next;
        fault_reg     <= fault_next;
    end

    assign done             = done_reg;
    assign frame_number     = frame_reg;
    assign physical_address = phys_reg;
    assign tlb_hit          = hit_reg;
    assign page_fault       = fault_reg;

    // A result only ever follows a lookup cycle.
    a_done_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_LOOKUP))
        else $error("result without a preceding lookup");

    // An accepted request always moves into the lookup cycle.
    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_LOOKUP))
        else $error("accepted request did not start a lookup");

    // The fill count never passes the number of TLB slots.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tlb_fill_reg <= FILL_W'(TLB_ENTRIES))
        else $error("TLB fill count out of range");

    // A TLB hit can never also be a page fault.
    a_hit_not_fault: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(tlb_hit && page_fault))
        else $error("result flagged as both hit and fault");

endmodule

[sim/tlb_page_table_translator_test.sv]
// Self-checking testbench for the TLB and page table address translator.
module tlb_page_table_translator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import tlbpt_pkg::*;

    localparam int TLB_DEPTH  = TLB_ENTRIES_DEF;
    localparam int PAGE_W     = PAGE_BITS_DEF;
    localparam int OFFSET_W   = OFFSET_BITS_DEF;
    localparam int PAGE_COUNT = 1 << PAGE_W;
    localparam int RANDOM_REQUESTS = 476;
    localparam int RECENT_DEPTH    = 24;

    // One translation as the block should report it.
    typedef struct {
        logic [FRAME_W-1:0] frame;
        logic [ADDR_W-1:0]  phys;
        logic               hit;
        logic               fault;
        logic [COUNT_W-1:0] hits;
        logic [COUNT_W-1:0] faults;
    } translation_t;

    // The scoreboard keeps its own copy of the TLB, the page table, the frame
    // allocator and both counters. Each accepted request is translated here at
    // once, and the expected translation waits in a queue until the block
    // reports it.
    class translation_scoreboard;
        logic [PAGE_W-1:0]      tlb_page [TLB_DEPTH];
        logic [FRAME_W-1:0]     tlb_frame [TLB_DEPTH];
        int                     tlb_count;
        bit                     page_present [PAGE_COUNT];
        logic [FRAME_W-1:0]     page_frame [PAGE_COUNT];
        logic [NEXT_FREE_W-1:0] next_free;
        logic [COUNT_W-1:0]     hit_count;
        logic [COUNT_W-1:0]     fault_count;
        translation_t           expected_q [$];
        int                     errors;

        function new();
            tlb_count   = 0;
            next_free   = '0;
            hit_count   = '0;
            fault_count = '0;
            errors      = 0;
            foreach (page_present[p])
                page_present[p] = 1'b0;
        endfunction

        // The counters hold once they reach the top value.
        function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] count);
            return (count == '1) ? count : count + 1'b1;
        endfunction

        // Drop the TLB slot at pos; newer entries slide one slot toward the oldest.
        function void tlb_drop(int pos);
            int i;
            for (i = pos; i < tlb_count - 1; i++)
            begin
                tlb_page[i]  = tlb_page[i + 1];
                tlb_frame[i] = tlb_frame[i + 1];
            end
            tlb_count--;
        endfunction

        function void note_request(logic [ADDR_W-1:0] addr);
            logic [PAGE_W-1:0]   page;
            logic [OFFSET_W-1:0] offset;
            translation_t        t;
            int                  pos;
            int                  i;
            page    = addr[OFFSET_W +: PAGE_W];
            offset  = addr[OFFSET_W-1:0];
            t.hit   = 1'b0;
            t.fault = 1'b0;
            t.frame = '0;
            pos     = -1;
            // Only filled slots take part in the compare.
            for (i = 0; i < tlb_count; i++)
            begin
                if (pos < 0 && tlb_page[i] == page)
                    pos = i;
            end
            if (pos >= 0)
            begin
                t.hit     = 1'b1;
                t.frame   = tlb_frame[pos];
                tlb_drop(pos);
                hit_count = bump(hit_count);
            end
            else if (page_present[page])
            begin
                t.frame = page_frame[page];
            end
            else
            begin
                // Frames are handed out in order and wrap without any check.
                t.fault            = 1'b1;
                t.frame            = next_free[FRAME_W-1:0];
                page_present[page] = 1'b1;
                page_frame[page]   = t.frame;
                next_free          = next_free + 1'b1;
                fault_count        = bump(fault_count);
            end
            // The translation becomes the newest entry; a full TLB loses its oldest.
            if (tlb_count == TLB_DEPTH)
                tlb_drop(0);
            tlb_page[tlb_count]  = page;
            tlb_frame[tlb_count] = t.frame;
            tlb_count++;
            t.phys   = ADDR_W'({t.frame, offset});
            t.hits   = hit_count;
            t.faults = fault_count;
            expected_q.push_back(t);
        endfunction

        function void check_field(string name, logic [COUNT_W-1:0] want,
                                  logic [COUNT_W-1:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [FRAME_W-1:0] frame, logic [ADDR_W-1:0] phys,
                                   logic hit, logic fault,
                                   logic [COUNT_W-1:0] hits, logic [COUNT_W-1:0] faults);
            translation_t t;
            if (expected_q.size() == 0)
            begin
                $error("translation reported with no request outstanding: frame 0x%0h",
                       frame);
                errors++;
                return;
            end
            t = expected_q.pop_front();
            check_field("frame_number", COUNT_W'(t.frame), COUNT_W'(frame));
            check_field("physical_address", COUNT_W'(t.phys), COUNT_W'(phys));
            check_field("tlb_hit", COUNT_W'(t.hit), COUNT_W'(hit));
            check_field("page_fault", COUNT_W'(t.fault), COUNT_W'(fault));
            check_field("hit_total", t.hits, hits);
            check_field("fault_total", t.faults, faults);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [ADDR_W-1:0]  virt_addr = '0;
    logic               busy;
    logic               done;
    logic [FRAME_W-1:0] frame_number;
    logic [ADDR_W-1:0]  physical_address;
    logic               tlb_hit;
    logic               page_fault;
    logic [COUNT_W-1:0] hit_total;
    logic [COUNT_W-1:0] fault_total;

    translation_scoreboard sb = new();

    tlb_page_table_translator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .virt_addr        (virt_addr),
        .done             (done),
        .frame_number     (frame_number),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .hit_total        (hit_total),
        .fault_total      (fault_total)
    );

    always #5 clk = ~clk;

    // Results cannot be held off, so every cycle with done high is checked.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(frame_number, physical_address, tlb_hit, page_fault,
                            hit_total, fault_total);
    end

    // Mostly back to back, sometimes a short idle gap, now and then a long pause.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is
    // taken. A request with no gap keeps start high without lowering it first.
    task automatic issue_request(input logic [ADDR_W-1:0] addr, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        virt_addr <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(addr);
        @(negedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] page_address(int page);
        return ADDR_W'({PAGE_W'(page), OFFSET_W'($urandom)});
    endfunction

    initial
    begin
        int                sent;
        int                sweep_page;
        int                roll;
        int                gap;
        int                p;
        logic [ADDR_W-1:0] addr;
        logic [PAGE_W-1:0] recent [$];

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests. The block clears its page table first, which the
        // handshake absorbs. The sequence covers the address extremes, a hit that
        // must move its entry to the newest slot without a duplicate, a full TLB
        // evicting its oldest entry, and misses that find the page in the table.
        issue_request(16'h0000, 0);             // fault on the lowest page
        issue_request(16'h00FF, 0);             // TLB hit right behind it
        issue_request(16'hFFFF, pick_gap());    // fault on the highest page
        issue_request(16'hFF00, 0);             // hit on the newest entry
        issue_request(16'h0012, 0);             // hit on the oldest entry
        for (p = 1; p <= 15; p++)
            issue_request(page_address(p), pick_gap());
        issue_request(page_address(8'hFF), 0);  // evicted, found in the page table
        issue_request(page_address(8'h00), 0);  // evicted, found in the page table
        issue_request(page_address(8), 0);      // hit in the middle of the TLB
        issue_request(page_address(8'h80), pick_gap());

        // Random requests. One share sweeps every page so that all frames get
        // handed out, one share revisits recent pages for TLB hits, evictions
        // and page table hits, and the rest are uniform addresses. Every so
        // often a stretch runs back to back.
        sent       = 0;
        sweep_page = 0;
        while (sent < RANDOM_REQUESTS || sweep_page < PAGE_COUNT)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55 && sweep_page < PAGE_COUNT)
            begin
                addr = page_address(sweep_page);
                sweep_page++;
            end
            else if (roll < 75 && recent.size() > 0)
                addr = page_address(int'(recent[$urandom_range(0, recent.size() - 1)]));
            else
                addr = ADDR_W'($urandom);
            recent.push_back(addr[OFFSET_W +: PAGE_W]);
            if (recent.size() > RECENT_DEPTH)
                void'(recent.pop_front());
            gap = (sent % 64 < 16) ? 0 : pick_gap();
            issue_request(addr, gap);
            sent++;
        end
        start <= 1'b0;

        // Let every expected translation arrive, then watch a little longer for
        // anything the block reports without a request behind it.
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // A hung handshake ends the run here.
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
